FILE: design/apsq_pkg.sv
package apsq_pkg;

   // queue geometry
   localparam int SLOTS       = 64;
   localparam int SLOT_FRAMES = 4096;
   localparam int SLOT_BITS   = $clog2(SLOTS);
   localparam int PTR_BITS    = SLOT_BITS + 1;
   localparam int POS_BITS    = $clog2(SLOT_FRAMES);
   localparam int LEN_BITS    = POS_BITS + 1;
   localparam int ADDR_BITS   = SLOT_BITS + POS_BITS;

   // field widths
   localparam int TIME_W  = 48;
   localparam int CFG_W   = 13;
   localparam int CAP_W   = 15;
   localparam int FAULT_W = 3;
   localparam int CMP_W   = 16;

   localparam logic [CFG_W-1:0]  MAX_FRAMES_RESET = 13'd4096;
   localparam logic [TIME_W-1:0] ONE_SAMPLE       = 48'd256;
   localparam logic [TIME_W:0]   HALF_SAMPLE      = 49'd128;
   localparam logic [TIME_W:0]   NEG_HALF_SAMPLE  = ~HALF_SAMPLE + 49'd1;

   // item kinds
   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_POP   = 2'd1;
   localparam logic [1:0] KIND_INVAL = 2'd2;

   // fault codes
   localparam logic [FAULT_W-1:0] FAULT_NONE     = 3'd0;
   localparam logic [FAULT_W-1:0] FAULT_CAPACITY = 3'd1;
   localparam logic [FAULT_W-1:0] FAULT_TIME     = 3'd2;
   localparam logic [FAULT_W-1:0] FAULT_DISCONT  = 3'd3;
   localparam logic [FAULT_W-1:0] FAULT_NONFIN   = 3'd4;
   localparam logic [FAULT_W-1:0] FAULT_OVERFLOW = 3'd5;
   localparam logic [FAULT_W-1:0] FAULT_CONFIG   = 3'd6;

   typedef struct packed {
      logic [1:0]        kind;
      logic [31:0]       sample;
      logic              first_of_packet;
      logic              last_of_packet;
      logic [TIME_W-1:0] sample_time;
      logic              time_valid;
      logic [CAP_W-1:0]  capacity;
   } req_type;

   typedef struct packed {
      logic [31:0]        data;
      logic               has_data;
      logic               packet_end;
      logic [FAULT_W-1:0] fault;
   } rsp_type;

   typedef struct packed {
      logic                 sample_we;
      logic [ADDR_BITS-1:0] sample_addr;
      logic [31:0]          sample_data;
      logic                 len_we;
      logic [SLOT_BITS-1:0] len_addr;
      logic [LEN_BITS-1:0]  len_data;
   } store_wr_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] sample_addr;
      logic [SLOT_BITS-1:0] len_addr;
   } store_rd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

FILE: design/apsq_store.sv
module apsq_store (
   input  logic                  clock,
   input  apsq_pkg::store_wr_type wr,
   input  apsq_pkg::store_rd_type rd,
   output logic [31:0]            sample_q,
   output logic [apsq_pkg::LEN_BITS-1:0] len_q
);
   import apsq_pkg::*;

   logic [31:0]         sample_mem [SLOTS*SLOT_FRAMES];
   logic [LEN_BITS-1:0] len_mem    [SLOTS];

   // sample words, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr.sample_we) begin
         sample_mem[wr.sample_addr] <= wr.sample_data;
      end
      sample_q <= sample_mem[rd.sample_addr];
   end

   // committed packet length per slot
   always_ff @(posedge clock) begin
      if (wr.len_we) begin
         len_mem[wr.len_addr] <= wr.len_data;
      end
      len_q <= len_mem[rd.len_addr];
   end

endmodule

FILE: design/audio_packet_slot_queue_top.sv
// Requests enter an execute state that waits while a held result is stalled; the result
// beat is registered when it finishes, and no new request is taken before. The store reads
//   sample and slot length at the accept edge; update and write-back happen in execute.
// A new request is taken while the previous result still waits on rsp_stall.
// Reset: synchronous, active high; clears pointers, time tracking and the fault code.
//   The sample and slot length memories are not cleared and need no clearing pass.
module audio_packet_slot_queue_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  apsq_pkg::req_type                   req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output apsq_pkg::rsp_type                   rsp_data,
   // max_frames register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apsq_pkg::CFG_W-1:0]          csr_data
);
   import apsq_pkg::*;

   // min over nonzero fault codes
   function automatic logic [FAULT_W-1:0] pend_min(input logic [FAULT_W-1:0] cur,
                                                   input logic [FAULT_W-1:0] code);
      logic [FAULT_W-1:0] r;
      r = ((cur == FAULT_NONE) || (code < cur)) ? code : cur;
      return r;
   endfunction

   // control and queue state
   state_type            state_ff,   state_in;
   req_type              item_ff,    item_in;
   rsp_type              rsp_ff,     rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0]     max_frames_ff, max_frames_in;
   logic [PTR_BITS-1:0]  ws_ff, ws_in;          // write slot, modulo 2*SLOTS
   logic [PTR_BITS-1:0]  rs_ff, rs_in;          // read slot, modulo 2*SLOTS
   logic [LEN_BITS-1:0]  wpos_ff, wpos_in;
   logic [POS_BITS-1:0]  rpos_ff, rpos_in;
   logic [TIME_W-1:0]    exp_ff, exp_in;
   logic                 known_ff, known_in;
   logic [FAULT_W-1:0]   fault_ff, fault_in;
   logic                 open_ff, open_in;      // packet open
   logic [FAULT_W-1:0]   pend_ff, pend_in;      // pending fault of open packet

   // memory side
   store_wr_type         st_wr;
   store_rd_type         st_rd;
   logic [31:0]          sample_q;
   logic [LEN_BITS-1:0]  len_q;

   // work signals
   logic                 exec_go;
   rsp_type              result;
   logic [CMP_W-1:0]     limit;
   logic [LEN_BITS-1:0]  pos;
   logic [LEN_BITS-1:0]  pos_next;
   logic [FAULT_W-1:0]   pend;
   logic [TIME_W-1:0]    exp_base;
   logic [TIME_W:0]      tdiff;
   logic                 far;
   logic [PTR_BITS-1:0]  queued;
   logic                 nonfinite;
   logic [LEN_BITS-1:0]  rpos_next;

   apsq_store u_store (
      .clock    (clock),
      .wr       (st_wr),
      .rd       (st_rd),
      .sample_q (sample_q),
      .len_q    (len_q)
   );

   // reads always point at the head of the read slot; the data is captured
   // at the accept edge and consumed in the execute cycle
   assign st_rd.sample_addr = {rs_ff[SLOT_BITS-1:0], rpos_ff};
   assign st_rd.len_addr    = rs_ff[SLOT_BITS-1:0];

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // push helpers
   assign limit = (CMP_W'(max_frames_ff) < CMP_W'(SLOT_FRAMES)) ?
                  CMP_W'(max_frames_ff) : CMP_W'(SLOT_FRAMES);
   assign pos       = item_ff.first_of_packet ? '0 : wpos_ff;
   assign pos_next  = pos + LEN_BITS'(1);
   // |t - expected| > half a sample, as a signed 49-bit window test
   assign tdiff     = {1'b0, item_ff.sample_time} - {1'b0, exp_ff};
   assign far       = tdiff[TIME_W] ? (tdiff < NEG_HALF_SAMPLE) : (tdiff > HALF_SAMPLE);
   assign queued    = ws_ff - rs_ff;
   assign nonfinite = (item_ff.sample[30:23] == 8'hFF);
   assign rpos_next = {1'b0, rpos_ff} + LEN_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      max_frames_in = max_frames_ff;
      ws_in         = ws_ff;
      rs_in         = rs_ff;
      wpos_in       = wpos_ff;
      rpos_in       = rpos_ff;
      exp_in        = exp_ff;
      known_in      = known_ff;
      fault_in      = fault_ff;
      open_in       = open_ff;
      pend_in       = pend_ff;
      st_wr         = '0;
      result        = '0;
      pend          = FAULT_NONE;
      exp_base      = exp_ff;

      if (csr_valid) begin
         max_frames_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
               case (item_ff.kind)
                  KIND_PUSH: begin
                     if ((fault_ff == FAULT_NONE) &&
                         (item_ff.first_of_packet || open_ff)) begin
                        if (item_ff.first_of_packet) begin
                           // restart drops any open packet
                           open_in = 1'b1;
                           pend_in = FAULT_NONE;
                           wpos_in = '0;
                        end
                        if (CMP_W'(pos) >= limit) begin
                           fault_in = FAULT_CAPACITY;
                        end else begin
                           pend = item_ff.first_of_packet ? FAULT_NONE : pend_ff;
                           if (item_ff.first_of_packet) begin
                              if (!item_ff.time_valid) begin
                                 pend = pend_min(pend, FAULT_TIME);
                              end else if (known_ff && far) begin
                                 pend = pend_min(pend, FAULT_DISCONT);
                              end else begin
                                 exp_base = item_ff.sample_time;
                                 known_in = 1'b1;
                              end
                           end
                           if (nonfinite) begin
                              pend = pend_min(pend, FAULT_NONFIN);
                           end
                           if (item_ff.first_of_packet &&
                               (queued >= PTR_BITS'(SLOTS))) begin
                              pend = pend_min(pend, FAULT_OVERFLOW);
                           end
                           if (pend == FAULT_NONE) begin
                              st_wr.sample_we   = 1'b1;
                              st_wr.sample_addr = {ws_ff[SLOT_BITS-1:0], pos[POS_BITS-1:0]};
                              st_wr.sample_data = item_ff.sample;
                           end
                           wpos_in = pos_next;
                           exp_in  = exp_base + ONE_SAMPLE;
                           if (item_ff.last_of_packet) begin
                              open_in = 1'b0;
                              pend_in = FAULT_NONE;
                              if (pend != FAULT_NONE) begin
                                 fault_in = pend;
                              end else begin
                                 st_wr.len_we   = 1'b1;
                                 st_wr.len_addr = ws_ff[SLOT_BITS-1:0];
                                 st_wr.len_data = pos_next;
                                 ws_in          = ws_ff + PTR_BITS'(1);
                                 wpos_in        = '0;
                              end
                           end else begin
                              pend_in = pend;
                           end
                        end
                     end
                  end
                  KIND_POP: begin
                     if ((fault_ff == FAULT_NONE) && (rs_ff != ws_ff)) begin
                        if ((rpos_ff == '0) &&
                            (CMP_W'(len_q) > CMP_W'(item_ff.capacity))) begin
                           fault_in = FAULT_CAPACITY;
                        end else begin
                           result.data     = sample_q;
                           result.has_data = 1'b1;
                           if (rpos_next >= len_q) begin
                              result.packet_end = 1'b1;
                              rpos_in           = '0;
                              rs_in             = rs_ff + PTR_BITS'(1);
                           end else begin
                              rpos_in = rpos_next[POS_BITS-1:0];
                           end
                        end
                     end
                  end
                  KIND_INVAL: begin
                     if (fault_ff == FAULT_NONE) begin
                        fault_in = FAULT_CONFIG;
                     end
                  end
                  default: begin
                  end
               endcase
               result.fault = fault_in;
               rsp_in       = result;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         max_frames_ff <= MAX_FRAMES_RESET;
         ws_ff         <= '0;
         rs_ff         <= '0;
         wpos_ff       <= '0;
         rpos_ff       <= '0;
         exp_ff        <= '0;
         known_ff      <= 1'b0;
         fault_ff      <= FAULT_NONE;
         open_ff       <= 1'b0;
         pend_ff       <= FAULT_NONE;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_frames_ff <= max_frames_in;
         ws_ff         <= ws_in;
         rs_ff         <= rs_in;
         wpos_ff       <= wpos_in;
         rpos_ff       <= rpos_in;
         exp_ff        <= exp_in;
         known_ff      <= known_in;
         fault_ff      <= fault_in;
         open_ff       <= open_in;
         pend_ff       <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

endmodule

FILE: dv/tb.sv
module tb;
   import apsq_pkg::*;

   // kind 3 has no meaning to the block and must change nothing
   localparam logic [1:0] KIND_SPARE = 2'd3;
   // cycles with no beat on any channel before the run is declared hung
   localparam int QUIET_LIMIT = 5000;
   // longest receiver hold-off in the backpressure test
   localparam int HOLD_CYCLES = 300;

   typedef enum int {
      LATCH_CONFIG,
      LATCH_OVERLONG,
      LATCH_ZERO_LIMIT,
      LATCH_POP_CAPACITY,
      LATCH_TIME,
      LATCH_DISCONT,
      LATCH_NONFINITE,
      LATCH_OVERFLOW
   } latch_case_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data  = '0;

   audio_packet_slot_queue_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Slot queue predictor: its own copy of pointers, time tracking, faults
   // ---------------------------------------------------------------------
   logic [31:0]         sample_mem [int];      // only written entries are ever read
   int                  slot_len [SLOTS];
   logic [PTR_BITS-1:0] wr_slot = '0;          // pointers run modulo 2*SLOTS
   logic [PTR_BITS-1:0] rd_slot = '0;
   int                  wr_pos = 0;
   int                  rd_pos = 0;
   logic [TIME_W-1:0]   next_time = '0;        // expected start of the next sample
   logic                time_locked = 1'b0;
   logic [FAULT_W-1:0]  latched_fault = FAULT_NONE;
   logic [FAULT_W-1:0]  pending_fault = FAULT_NONE;
   logic                pkt_open = 1'b0;
   logic [CFG_W-1:0]    max_frames = MAX_FRAMES_RESET;

   rsp_type queued_replies [$];                // predicted result beats, oldest first
   int      items_sent = 0;
   int      fail_count = 0;
   bit      steady = 1'b0;                     // both sides stop idling while set
   int      hold_request = 0;                  // receiver hold-off asked by the stimulus
   int      hold_left = 0;

   function automatic int queue_depth();
      logic [PTR_BITS-1:0] diff;
      diff = wr_slot - rd_slot;
      return int'(diff);
   endfunction

   function automatic int limit_now();
      return (int'(max_frames) < SLOT_FRAMES) ? int'(max_frames) : SLOT_FRAMES;
   endfunction

   // lowest nonzero code wins among the faults held for the open packet
   function automatic void hold_fault(logic [FAULT_W-1:0] code);
      if (pending_fault == FAULT_NONE || code < pending_fault) pending_fault = code;
   endfunction

   function automatic void push_sample(req_type it);
      logic [TIME_W-1:0] gap;
      if (latched_fault != FAULT_NONE) return;
      if (it.first_of_packet) begin
         // a first mark drops whatever packet was open, with its held fault
         pkt_open      = 1'b1;
         pending_fault = FAULT_NONE;
         wr_pos        = 0;
      end else if (!pkt_open) begin
         return;
      end
      if (wr_pos >= limit_now()) begin
         latched_fault = FAULT_CAPACITY;
         return;
      end
      if (it.first_of_packet) begin
         gap = (it.sample_time >= next_time) ? it.sample_time - next_time
                                             : next_time - it.sample_time;
         if (!it.time_valid) hold_fault(FAULT_TIME);
         else if (time_locked && gap > HALF_SAMPLE) hold_fault(FAULT_DISCONT);
         else begin
            next_time   = it.sample_time;
            time_locked = 1'b1;
         end
      end
      if (&it.sample[30:23]) hold_fault(FAULT_NONFIN);
      if (it.first_of_packet && queue_depth() >= SLOTS) hold_fault(FAULT_OVERFLOW);
      if (pending_fault == FAULT_NONE)
         sample_mem[int'(wr_slot[SLOT_BITS-1:0]) * SLOT_FRAMES + wr_pos] = it.sample;
      wr_pos++;
      next_time = next_time + ONE_SAMPLE;
      if (it.last_of_packet) begin
         pkt_open = 1'b0;
         if (pending_fault != FAULT_NONE) begin
            latched_fault = pending_fault;
            pending_fault = FAULT_NONE;
            return;
         end
         slot_len[wr_slot[SLOT_BITS-1:0]] = wr_pos;
         wr_slot = wr_slot + 1'b1;
         wr_pos  = 0;
      end
   endfunction

   function automatic rsp_type pop_sample(logic [CAP_W-1:0] cap);
      rsp_type r;
      int      slot;
      r = '0;
      if (latched_fault != FAULT_NONE || rd_slot == wr_slot) return r;
      slot = int'(rd_slot[SLOT_BITS-1:0]);
      // capacity only matters at the start of a slot
      if (rd_pos == 0 && slot_len[slot] > int'(cap)) begin
         latched_fault = FAULT_CAPACITY;
         return r;
      end
      r.data     = sample_mem[slot * SLOT_FRAMES + rd_pos];
      r.has_data = 1'b1;
      rd_pos++;
      if (rd_pos >= slot_len[slot]) begin
         r.packet_end = 1'b1;
         rd_pos       = 0;
         rd_slot      = rd_slot + 1'b1;
      end
      return r;
   endfunction

   function automatic rsp_type slot_queue_step(req_type it);
      rsp_type r;
      r = '0;
      case (it.kind)
         KIND_PUSH:  push_sample(it);
         KIND_POP:   r = pop_sample(it.capacity);
         KIND_INVAL: if (latched_fault == FAULT_NONE) latched_fault = FAULT_CONFIG;
         default:    ;
      endcase
      r.fault = latched_fault;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Item builders: unused fields always carry random bits
   // ---------------------------------------------------------------------
   function automatic logic [TIME_W-1:0] junk_time();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[TIME_W-1:0];
   endfunction

   function automatic logic [31:0] finite_sample();
      logic [31:0] s;
      do s = $urandom; while (&s[30:23]);
      return s;
   endfunction

   // start time within half a sample of the tracked time, free before lock
   function automatic logic [TIME_W-1:0] first_time();
      int off;
      if (!time_locked) return junk_time();
      off = $urandom_range(256) - 128;
      if (next_time < 48'd128 && off < 0) off = -off;
      if (next_time > ~48'd128 && off > 0) off = -off;
      return next_time + 48'(off);
   endfunction

   function automatic req_type random_item(logic [1:0] kind);
      req_type it;
      it.kind            = kind;
      it.sample          = $urandom;
      it.first_of_packet = 1'($urandom_range(1));
      it.last_of_packet  = 1'($urandom_range(1));
      it.sample_time     = junk_time();
      it.time_valid      = 1'($urandom_range(1));
      it.capacity        = CAP_W'($urandom);
      return it;
   endfunction

   function automatic req_type push_req(logic [31:0] s, logic first, logic last,
                                        logic [TIME_W-1:0] t, logic tv);
      req_type it;
      it                 = random_item(KIND_PUSH);
      it.sample          = s;
      it.first_of_packet = first;
      it.last_of_packet  = last;
      it.sample_time     = t;
      it.time_valid      = tv;
      return it;
   endfunction

   function automatic req_type pop_cap_req(logic [CAP_W-1:0] cap);
      req_type it;
      it          = random_item(KIND_POP);
      it.capacity = cap;
      return it;
   endfunction

   // pop that never trips the capacity check: at a slot start it fits the slot
   function automatic req_type pop_req();
      int n;
      if (rd_slot != wr_slot && rd_pos == 0) begin
         n = slot_len[rd_slot[SLOT_BITS-1:0]];
         if ($urandom_range(3) == 0) return pop_cap_req(CAP_W'(n));
         return pop_cap_req(CAP_W'($urandom_range(32767, n)));
      end
      return pop_cap_req(CAP_W'($urandom));
   endfunction

   function automatic int packet_len();
      int hi;
      hi = ($urandom_range(9) == 0) ? 64 : 6;
      if (hi > limit_now()) hi = limit_now();
      return $urandom_range(hi, 1);
   endfunction

   // ---------------------------------------------------------------------
   // Handshake tasks
   // ---------------------------------------------------------------------
   // Offers one beat and predicts it once accepted. Valid stays high after the
   // beat; the caller either offers the next beat or calls wait_drained.
   task automatic send_item(req_type it);
      while (!steady && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      queued_replies.push_back(slot_queue_step(it));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (queued_replies.size() != 0);
   endtask

   task automatic write_max_frames(logic [CFG_W-1:0] value);
      wait_drained();
      repeat (4) @(posedge clock);       // covers the write-back after the last beat
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid  <= 1'b0;
      max_frames = value;
   endtask

   // clean packet; pops first if the queue is full so it can never overflow
   task automatic send_packet(int len);
      while (queue_depth() >= SLOTS) send_item(pop_req());
      for (int i = 0; i < len; i++) begin
         if (i == 0) send_item(push_req(finite_sample(), 1'b1, len == 1, first_time(), 1'b1));
         else send_item(push_req(finite_sample(), 1'b0, i == len - 1, junk_time(),
                                 1'($urandom_range(1))));
      end
   endtask

   task automatic pop_all();
      while (queue_depth() > 0) send_item(pop_req());
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed_cases();
      send_item(pop_cap_req('0));                          // pop on an empty queue
      send_item(random_item(KIND_SPARE));
      send_item(push_req($urandom, 1'b0, 1'b1, junk_time(), 1'b1));   // stray push
      // one-sample packet at the top of the time range; tracked time wraps
      send_item(push_req(32'h0000_0000, 1'b1, 1'b1, 48'hFFFF_FFFF_FF80, 1'b1));
      // start exactly half a sample off: still continuous
      send_item(push_req(32'hFF7F_FFFF, 1'b1, 1'b0, next_time + 48'd128, 1'b1));
      send_item(push_req(32'h8000_0000, 1'b0, 1'b0, junk_time(), 1'b0));
      send_item(push_req(32'h7F7F_FFFF, 1'b0, 1'b1, junk_time(), 1'b1));
      send_item(pop_cap_req(15'd1));                       // capacity equals slot length
      send_item(pop_cap_req(15'h7FFF));
      send_item(pop_cap_req(15'd0));                       // mid-slot, capacity ignored
      send_item(pop_cap_req(15'd0));
      // held faults, each dropped by the restart that follows
      send_item(push_req(finite_sample(), 1'b1, 1'b0, first_time(), 1'b0));
      send_item(push_req(finite_sample(), 1'b1, 1'b0, next_time + 48'd129, 1'b1));
      send_item(push_req(finite_sample(), 1'b0, 1'b0, junk_time(), 1'b1));
      send_item(push_req(32'h7F80_0000, 1'b1, 1'b0, next_time, 1'b1));   // infinity
      send_item(push_req(32'hFFFF_FFFF, 1'b0, 1'b0, junk_time(), 1'b1)); // NaN
      // clean open packet dropped by a restart
      send_item(push_req(finite_sample(), 1'b1, 1'b0, first_time(), 1'b1));
      send_packet(2);
      pop_all();
   endtask

   task automatic test_frame_limits();
      write_max_frames(13'd1);
      repeat (2) send_packet(1);
      pop_all();
      write_max_frames(13'd7);
      send_packet(7);
      pop_all();
      write_max_frames(13'd8191);                          // clipped to the slot size
      send_packet(32);
      pop_all();
   endtask

   task automatic test_overflow_pending();
      pop_all();
      repeat (SLOTS) send_packet(1);
      // queue full at the first sample: overflow is held, not latched
      send_item(push_req(finite_sample(), 1'b1, 1'b0, first_time(), 1'b1));
      send_item(pop_req());
      send_packet(2);
      pop_all();
   endtask

   task automatic test_random_traffic(int quota);
      logic [CFG_W-1:0]   settings [6];
      logic [FAULT_W-1:0] flaws [4];
      logic [FAULT_W-1:0] flaw;
      req_type            it;
      int                 goal;
      int                 pick;
      int                 len;
      flaws    = '{FAULT_NONE, FAULT_TIME, FAULT_DISCONT, FAULT_NONFIN};
      settings = '{13'd1, 13'd8191, 13'd2, 13'd4096, 13'd1, 13'd3};
      settings[2] = CFG_W'($urandom_range(16, 2));
      settings[4] = CFG_W'($urandom_range(8191, 1));
      settings[5] = CFG_W'($urandom_range(64, 3));
      for (int ph = 0; ph < 6; ph++) begin
         write_max_frames(settings[ph]);
         steady = (ph == 2);
         goal   = items_sent + quota / 6;
         while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 45) send_packet(packet_len());
            else if (pick < 85) send_item(pop_req());
            else if (pick < 89) send_item(random_item(KIND_SPARE));
            else if (pick < 93)
               send_item(push_req($urandom, 1'b0, 1'($urandom_range(1)), junk_time(),
                                  1'($urandom_range(1))));
            else begin
               // broken packet, maybe with a held fault, then a restart
               len  = $urandom_range((limit_now() < 4) ? limit_now() : 4, 1);
               flaw = flaws[$urandom_range(3)];
               for (int i = 0; i < len; i++) begin
                  it = push_req(finite_sample(), i == 0, 1'b0, junk_time(),
                                1'($urandom_range(1)));
                  if (i == 0) begin
                     it.sample_time = first_time();
                     it.time_valid  = (flaw != FAULT_TIME);
                     if (flaw == FAULT_DISCONT)
                        it.sample_time = next_time + 48'd129 + 48'($urandom_range(5000));
                  end
                  if (flaw == FAULT_NONFIN && i == len - 1) it.sample[30:23] = 8'hFF;
                  send_item(it);
               end
               send_packet(packet_len());
            end
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_request = HOLD_CYCLES;
      // keep offering while the receiver holds off, so the input stalls
      repeat (8) begin
         send_packet(1);
         send_item(pop_req());
      end
      wait_drained();
   endtask

   // one fault, picked at random, latches for good; later beats change nothing
   task automatic test_sticky_fault();
      latch_case_type scenario;
      req_type        it;
      scenario = latch_case_type'($urandom_range(7));
      write_max_frames(MAX_FRAMES_RESET);
      pop_all();
      case (scenario)
         LATCH_CONFIG: send_item(random_item(KIND_INVAL));
         LATCH_OVERLONG: begin
            write_max_frames(13'd2);
            send_item(push_req(finite_sample(), 1'b1, 1'b0, first_time(), 1'b1));
            repeat (2) send_item(push_req(finite_sample(), 1'b0, 1'b0, junk_time(), 1'b1));
         end
         LATCH_ZERO_LIMIT: begin
            write_max_frames(13'd0);
            send_item(push_req(finite_sample(), 1'b1, 1'b1, first_time(), 1'b1));
         end
         LATCH_POP_CAPACITY: begin
            send_packet(3);
            send_item(pop_cap_req(CAP_W'($urandom_range(2))));
         end
         LATCH_TIME:
            send_item(push_req(finite_sample(), 1'b1, 1'b1, first_time(), 1'b0));
         LATCH_DISCONT:
            send_item(push_req(finite_sample(), 1'b1, 1'b1,
                               next_time + 48'd129 + 48'($urandom_range(1000)), 1'b1));
         LATCH_NONFINITE: begin
            send_item(push_req(finite_sample(), 1'b1, 1'b0, first_time(), 1'b1));
            it = push_req(finite_sample(), 1'b0, 1'b1, junk_time(), 1'b1);
            it.sample[30:23] = 8'hFF;
            send_item(it);
         end
         default: begin
            repeat (SLOTS) send_packet(1);
            send_item(push_req(finite_sample(), 1'b1, 1'b1, first_time(), 1'b1));
         end
      endcase
      repeat (24) send_item(random_item(2'($urandom_range(3))));
      send_item(random_item(KIND_INVAL));
   endtask

   // ---------------------------------------------------------------------
   // Result checking and receiver stall, one process
   // ---------------------------------------------------------------------
   function automatic void note_mismatch(string name, logic [31:0] want, logic [31:0] got);
      fail_count++;
      if (fail_count <= 40) $error("%s mismatch: expected %0h, got %0h", name, want, got);
   endfunction

   always @(posedge clock) begin : reply_check
      rsp_type want;
      // values read here are the ones sampled at this edge
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (queued_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= 40) $error("result beat with no prediction waiting");
         end else begin
            want = queued_replies.pop_front();
            if (rsp_data.data !== want.data) note_mismatch("data", want.data, rsp_data.data);
            if (rsp_data.has_data !== want.has_data)
               note_mismatch("has_data", want.has_data, rsp_data.has_data);
            if (rsp_data.packet_end !== want.packet_end)
               note_mismatch("packet_end", want.packet_end, rsp_data.packet_end);
            if (rsp_data.fault !== want.fault)
               note_mismatch("fault", want.fault, rsp_data.fault);
         end
      end
      // hold-off counted here, otherwise random stalls unless steady
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 15);
      end
   end

   // watchdog: any beat on any channel restarts the count
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && !rsp_stall) || (csr_valid && csr_ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("audio_packet_slot_queue_top test failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_frame_limits();
      test_overflow_pending();
      test_random_traffic(1500);
      test_backpressure();
      test_sticky_fault();
      wait_drained();
      repeat (10) @(posedge clock);      // catch any stray late beat
      if (fail_count == 0)
         $display("audio_packet_slot_queue_top test passed");
      else
         $display("audio_packet_slot_queue_top test failed");
      $finish;
   end

endmodule

FILE: sim.f
design/apsq_pkg.sv
design/apsq_store.sv
design/audio_packet_slot_queue_top.sv
dv/tb.sv
